/* hw/rtl/bounded_list_edit_engine_top_defines.svh */
// ---------------------------------------------------------------------------
// bounded list edit engine assertion macros
// shared property shapes for the checker, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIST_EDIT_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_LIST_EDIT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define BLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ble check failed");

// next-cycle implication
`define BLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ble check failed");

`endif

/* hw/rtl/ble_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ble_pkg
// types, codes and defaults shared by the list edit engine modules
// ---------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned CNT_W     = 6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_VALUE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // read pointer update
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_AFTER_MATCH
  } ptr_op_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    append_wr;
    logic    dec_count;
    logic    rd_en;
    logic    shift_mode;
    logic    set_status;
    status_t status;
    ptr_op_t ptr_op;
    logic    load_res;
    logic    load_elem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_more;
    logic pend;
    logic match;
    logic out_free;
    logic last_elem;
  } dp_sts_t;

endpackage

/* hw/rtl/ble_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ble_dp
// element memory, count and read pointer, compare and result register
// ---------------------------------------------------------------------------
module ble_dp #(
  parameter int unsigned DEPTH = ble_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ble_pkg::VAL_W-1:0]     in_value,
  input  ble_pkg::dp_cmd_t              cmd,
  output ble_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ble_pkg::VAL_W-1:0]     out_elem_value,
  output logic                          out_elem_valid,
  output logic [ble_pkg::CNT_W-1:0]     out_list_count,
  output logic [1:0]                    out_status,
  output logic                          out_last_result
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned VW   = ble_pkg::VAL_W;
  localparam int unsigned CNTW = ble_pkg::CNT_W;

  logic [VW-1:0]    mem [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [VW-1:0]    value_r;
  logic [VW-1:0]    rd_data_r;
  logic             pend_r;
  logic [AW-1:0]    pend_ptr_r;
  ble_pkg::status_t status_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_elem_value_r;
  logic             out_elem_valid_r;
  logic [CNTW-1:0]  out_list_count_r;
  ble_pkg::status_t out_status_r;
  logic             out_last_result_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VW-1:0]    wr_data;
  logic             out_free;

  // memory write source: append at the tail or move one entry to the next lower address
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_value;
    if (cmd.append_wr) begin
      wr_en = 1'b1;
    end else if (cmd.shift_mode && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_ptr_r - AW'(1);
      wr_data = rd_data_r;
    end
  end

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r  <= mem[ptr_r[AW-1:0]];
      pend_ptr_r <= ptr_r[AW-1:0];
    end
  end

  // element count
  always_comb begin
    count_nxt = count_r;
    if (cmd.append_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // read pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.rd_en) begin
      ptr_nxt = ptr_r + CW'(1);
    end else begin
      case (cmd.ptr_op)
        ble_pkg::PTR_HOLD:        ptr_nxt = ptr_r;
        ble_pkg::PTR_ZERO:        ptr_nxt = '0;
        ble_pkg::PTR_ONE:         ptr_nxt = CW'(1);
        ble_pkg::PTR_AFTER_MATCH: ptr_nxt = CW'(pend_ptr_r) + CW'(1);
        default:                  ptr_nxt = ptr_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request value and status
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r <= in_value;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_res || cmd.load_elem) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_elem_value_r  <= '0;
      out_elem_valid_r  <= 1'b0;
      out_list_count_r  <= CNTW'(count_r);
      out_status_r      <= status_r;
      out_last_result_r <= 1'b1;
    end else if (cmd.load_elem) begin
      out_elem_value_r  <= rd_data_r;
      out_elem_valid_r  <= 1'b1;
      out_list_count_r  <= CNTW'(count_r);
      out_status_r      <= ble_pkg::ST_DONE;
      out_last_result_r <= (ptr_r == count_r);
    end
  end

  // status to controller
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.rd_more   = (ptr_r < count_r);
  assign sts.pend      = pend_r;
  assign sts.match     = pend_r && (rd_data_r == value_r);
  assign sts.out_free  = out_free;
  assign sts.last_elem = (ptr_r == count_r);

  assign out_valid       = out_valid_r;
  assign out_elem_value  = out_elem_value_r;
  assign out_elem_valid  = out_elem_valid_r;
  assign out_list_count  = out_list_count_r;
  assign out_status      = out_status_r;
  assign out_last_result = out_last_result_r;

endmodule

/* hw/rtl/ble_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ble_ctrl
// request sequencer: decode, scan, close-up, dump and result hand-off
// ---------------------------------------------------------------------------
module ble_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ble_pkg::REQ_W-1:0]     in_req_type,
  input  ble_pkg::dp_sts_t              sts,
  output ble_pkg::dp_cmd_t              cmd
);

  ble_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ble_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ble_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            ble_pkg::REQ_DEL_FIRST:
              state_nxt = sts.empty ? ble_pkg::S_RESULT : ble_pkg::S_SHIFT;
            ble_pkg::REQ_DEL_VALUE:
              state_nxt = sts.empty ? ble_pkg::S_RESULT : ble_pkg::S_SCAN;
            ble_pkg::REQ_DUMP:
              state_nxt = sts.empty ? ble_pkg::S_RESULT : ble_pkg::S_DUMP_RD;
            default:
              state_nxt = ble_pkg::S_RESULT;
          endcase
        end
      end
      ble_pkg::S_SCAN: begin
        if (sts.match) begin
          state_nxt = ble_pkg::S_SHIFT;
        end else if (!sts.rd_more && !sts.pend) begin
          state_nxt = ble_pkg::S_RESULT;
        end
      end
      ble_pkg::S_SHIFT: begin
        if (!sts.rd_more && !sts.pend) begin
          state_nxt = ble_pkg::S_RESULT;
        end
      end
      ble_pkg::S_DUMP_RD: begin
        state_nxt = ble_pkg::S_DUMP_OUT;
      end
      ble_pkg::S_DUMP_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_elem ? ble_pkg::S_IDLE : ble_pkg::S_DUMP_RD;
        end
      end
      ble_pkg::S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = ble_pkg::S_IDLE;
        end
      end
      default: state_nxt = ble_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ble_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ble_pkg::ST_DONE;
          case (in_req_type)
            ble_pkg::REQ_APPEND: begin
              if (sts.full) begin
                cmd.status = ble_pkg::ST_FULL;
              end else begin
                cmd.append_wr = 1'b1;
              end
            end
            ble_pkg::REQ_DEL_FIRST: begin
              if (sts.empty) begin
                cmd.status = ble_pkg::ST_EMPTY;
              end else begin
                cmd.ptr_op = ble_pkg::PTR_ONE;
              end
            end
            ble_pkg::REQ_DEL_LAST: begin
              if (sts.empty) begin
                cmd.status = ble_pkg::ST_EMPTY;
              end else begin
                cmd.dec_count = 1'b1;
              end
            end
            ble_pkg::REQ_DEL_VALUE, ble_pkg::REQ_DUMP: begin
              if (sts.empty) begin
                cmd.status = ble_pkg::ST_EMPTY;
              end else begin
                cmd.ptr_op = ble_pkg::PTR_ZERO;
              end
            end
            default: cmd.status = ble_pkg::ST_DONE;
          endcase
        end
      end
      ble_pkg::S_SCAN: begin
        if (sts.match) begin
          cmd.ptr_op = ble_pkg::PTR_AFTER_MATCH;
        end else if (sts.rd_more) begin
          cmd.rd_en = 1'b1;
        end else if (!sts.pend) begin
          cmd.set_status = 1'b1;
          cmd.status     = ble_pkg::ST_NOT_FOUND;
        end
      end
      ble_pkg::S_SHIFT: begin
        cmd.shift_mode = 1'b1;
        if (sts.rd_more) begin
          cmd.rd_en = 1'b1;
        end else if (!sts.pend) begin
          cmd.dec_count = 1'b1;
        end
      end
      ble_pkg::S_DUMP_RD: begin
        cmd.rd_en = 1'b1;
      end
      ble_pkg::S_DUMP_OUT: begin
        cmd.load_elem = sts.out_free;
      end
      ble_pkg::S_RESULT: begin
        cmd.load_res = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/bounded_list_edit_engine_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_list_edit_engine_top
// ordered list of up to DEPTH signed values edited one request at a time
// ---------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its last result
// has been loaded into the output register, which then waits for the sink
// while the next request is taken. Append, delete last and unused codes go
// straight to the result; delete first closes up the list behind the head, and
// delete value reads each element once, in the scan up to the match or in the
// close-up after it. A dump reads each element, then waits for a free output
// register before loading it. The element memory has one registered read and
// one write per cycle; scan and close-up move one element per cycle, and only
// the dump and result hand-off wait on output back-pressure. The memory needs
// no clearing after reset: only entries below the count are ever read.
module bounded_list_edit_engine_top #(
  parameter int unsigned DEPTH = ble_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ble_pkg::REQ_W-1:0]     in_req_type,
  input  logic signed [ble_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ble_pkg::VAL_W-1:0] out_elem_value,
  output logic                          out_elem_valid,
  output logic [ble_pkg::CNT_W-1:0]     out_list_count,
  output logic [1:0]                    out_status,
  output logic                          out_last_result
);

  ble_pkg::dp_cmd_t cmd;
  ble_pkg::dp_sts_t sts;

  // request sequencer
  ble_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd)
  );

  // storage and result path
  ble_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_elem_value  (out_elem_value),
    .out_elem_valid  (out_elem_valid),
    .out_list_count  (out_list_count),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule

/* hw/rtl/ble_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ble_checker
// port-level checks on the list edit engine, bound to the top level
// ---------------------------------------------------------------------------
`include "bounded_list_edit_engine_top_defines.svh"

module ble_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ble_pkg::VAL_W-1:0]     out_elem_value,
  input logic                          out_elem_valid,
  input logic [ble_pkg::CNT_W-1:0]     out_list_count,
  input logic [1:0]                    out_status,
  input logic                          out_last_result
);

  // a stalled transaction holds its element value, last flag and status
  `BLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_elem_value) && $stable(out_last_result) && $stable(out_status))

  // one request at a time: busy right after an accept
  `BLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a result without an element is always the only one of its request
  `BLE_ASSERT_SAME(a_plain_is_last, out_valid && !out_elem_valid, out_last_result)

  // dumped elements always report done
  `BLE_ASSERT_SAME(a_elem_done, out_valid && out_elem_valid, out_status == ble_pkg::ST_DONE)

endmodule

bind bounded_list_edit_engine_top ble_checker u_ble_checker (.*);
